// ===== rtl/differential_drive_odometry_core_macros.svh =====
// Assertion macros shared by the odometry RTL.
// Depends on nothing; included inside module bodies.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH

// Implication checked every cycle outside reset.
`define DDO_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define DDO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ddo_pkg.sv =====
// Package for the differential drive odometry block.
// Holds payload and control structs, constants, state enum and the arctangent table.
`default_nettype none
package ddo_pkg;

  typedef struct packed {
    logic signed [23:0] right_increment;
    logic signed [23:0] left_increment;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [31:0]        heading;
  } out_item_t;

  localparam logic [0:0] REG_WHEEL_RADIUS = 1'd0;
  localparam logic [0:0] REG_WHEEL_BASE   = 1'd1;
  localparam logic [15:0] RADIUS_RESET = 16'd3405;
  localparam logic [15:0] BASE_RESET   = 16'd6656;
  localparam logic [21:0] KPI          = 22'd2670177;
  localparam logic [16:0] TRAVEL_DIV   = 17'd51200;
  localparam logic [31:0] GAIN_INV     = 32'd652032874;

  // Sequencer states: idle, the multiply, divide and CORDIC passes, and output.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_DIV_T,
    ST_MUL_W,
    ST_MUL_K,
    ST_DIV_H,
    ST_CORDIC,
    ST_MUL_X,
    ST_MUL_Y,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } ser_ctl_t;

  function automatic logic [31:0] atan_lookup(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
        5'd20: r = 32'd652;       5'd21: r = 32'd326;
        5'd22: r = 32'd163;       5'd23: r = 32'd81;
        5'd24: r = 32'd41;        5'd25: r = 32'd20;
        5'd26: r = 32'd10;        5'd27: r = 32'd5;
        5'd28: r = 32'd3;         5'd29: r = 32'd1;
        5'd30: r = 32'd1;         default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ddo_serial_mul.sv =====
// Bit-serial shift-and-add multiplier of unsigned magnitudes.
// Uses ddo_pkg for the control struct; one multiplier bit per cycle.
`default_nettype none
module ddo_serial_mul (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ddo_pkg::ser_ctl_t   ctl_in,
  input  wire logic [63:0]         a,
  input  wire logic [31:0]         b,
  output      logic [63:0]         product,
  output      logic                done
);
  import ddo_pkg::*;
  `include "differential_drive_odometry_core_macros.svh"

  logic [63:0] acc;
  logic [63:0] mcand;
  logic [31:0] mplier;
  logic [5:0]  count;
  logic        run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        run    <= 1'b1;
        acc    <= '0;
        mcand  <= a;
        mplier <= b;
        count  <= 6'd0;
      end else if (run) begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= {mcand[62:0], 1'b0};
        mplier <= {1'b0, mplier[31:1]};
        count  <= count + 6'd1;
        if (count == 6'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;

  `DDO_ASSERT_NEXT(a_mul_done_pulse, clk, rst, done, !done,
                   "multiplier done held for two cycles")
  `DDO_ASSERT_IMP(a_mul_no_restart, clk, rst, run && !done, !ctl_in.start || !ctl_in.busy,
                  "multiplier restarted while running")
endmodule
`default_nettype wire

// ===== rtl/ddo_serial_div.sv =====
// Restoring bit-serial divider with round-half-up on unsigned magnitudes.
// Uses ddo_pkg; produces one quotient bit per cycle.
`default_nettype none
module ddo_serial_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ddo_pkg::ser_ctl_t   ctl_in,
  input  wire logic [63:0]         num,
  input  wire logic [31:0]         den,
  output      logic [63:0]         quot,
  output      logic                done
);
  import ddo_pkg::*;
  `include "differential_drive_odometry_core_macros.svh"

  logic [63:0] q;
  logic [32:0] rem;
  logic [31:0] d;
  logic [6:0]  count;
  logic        run;
  logic [32:0] trial;

  assign trial = {rem[31:0], q[63]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        run   <= 1'b1;
        // Adding half the divisor first gives rounding to nearest.
        q     <= num + {33'd0, den[31:1]};
        d     <= den;
        rem   <= '0;
        count <= 7'd0;
      end else if (run) begin
        if (!trial[32]) begin
          rem <= trial;
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], q[63]};
          q   <= {q[62:0], 1'b0};
        end
        count <= count + 7'd1;
        if (count == 7'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;

  `DDO_ASSERT_NEXT(a_div_done_pulse, clk, rst, done, !done,
                   "divider done held for two cycles")
  `DDO_ASSERT_IMP(a_div_rem_bound, clk, rst, run, rem < {1'b0, d},
                  "divider remainder not below divisor")
endmodule
`default_nettype wire

// ===== rtl/ddo_cordic.sv =====
// Iterative rotation-mode CORDIC giving sine and cosine in Q4.30 (34 bits, signed).
// Uses ddo_pkg for the arctangent table and gain; one rotation per cycle.
`default_nettype none
module ddo_cordic #(
  parameter int unsigned STEPS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ddo_pkg::ser_ctl_t  ctl_in,
  input  wire logic [31:0]        angle,
  output      logic signed [33:0] sin_out,
  output      logic signed [33:0] cos_out,
  output      logic               done
);
  import ddo_pkg::*;
  `include "differential_drive_odometry_core_macros.svh"

  localparam int unsigned LAST = STEPS - 1;

  logic signed [33:0] cx, cy, xs, ys;
  logic signed [32:0] cz;
  logic [4:0]  step;
  logic        run;
  logic        flip;
  logic [31:0] a_rot;

  assign a_rot = (angle[31] ^ angle[30]) ? angle - 32'h8000_0000 : angle;
  assign xs = cx >>> step;
  assign ys = cy >>> step;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        run  <= 1'b1;
        flip <= angle[31] ^ angle[30];
        cz   <= {a_rot[31], a_rot};
        cx   <= {2'b00, GAIN_INV};
        cy   <= '0;
        step <= 5'd0;
      end else if (run) begin
        if (!cz[32]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - $signed({1'b0, atan_lookup(step)});
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + $signed({1'b0, atan_lookup(step)});
        end
        step <= step + 5'd1;
        if (step == LAST[4:0]) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sin_out = flip ? -cy : cy;
  assign cos_out = flip ? -cx : cx;

  `DDO_ASSERT_NEXT(a_cor_done_pulse, clk, rst, done, !done,
                   "cordic done held for two cycles")
  `DDO_ASSERT_IMP(a_cor_step_range, clk, rst, run, step <= LAST[4:0],
                  "cordic step past the last rotation")
endmodule
`default_nettype wire

// ===== rtl/differential_drive_odometry_core.sv =====
// Differential drive odometry: each input beat carries the right and left
// wheel increments and yields one output beat with the updated pose. An item
// takes five passes of a bit-serial multiplier, two passes of a bit-serial
// divider, a CORDIC pass and the hand-over of the result. A new input beat
// is taken only in idle once the result has been taken. One item is in work
// at a time. The output register holds a finished beat until taken.
// No clearing pass.
`default_nettype none
module differential_drive_odometry_core #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire ddo_pkg::in_item_t    in_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      ddo_pkg::out_item_t   out_data,
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [15:0]          cfg_data
);
  import ddo_pkg::*;
  `include "differential_drive_odometry_core_macros.svh"

  state_t state, state_next, state_prev;
  logic enter;
  logic [15:0] radius, track_width;
  logic signed [31:0] x_position, y_position;
  logic [31:0] heading_angle;

  logic signed [24:0] sum_r, dif_r;
  logic [63:0] t_mag, h_mag;
  logic signed [33:0] s_lat, c_lat;
  logic [31:0] h_angle;

  ser_ctl_t mul_ctl, div_ctl, cor_ctl;
  logic [63:0] mul_a, mul_p, div_n, div_q;
  logic [31:0] mul_b, div_d;
  logic mul_done, div_done, cor_done;
  logic signed [33:0] sin_w, cos_w;

  ddo_serial_mul u_mul (.clk, .rst, .ctl_in(mul_ctl), .a(mul_a), .b(mul_b),
                        .product(mul_p), .done(mul_done));
  ddo_serial_div u_div (.clk, .rst, .ctl_in(div_ctl), .num(div_n), .den(div_d),
                        .quot(div_q), .done(div_done));
  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cor (.clk, .rst, .ctl_in(cor_ctl),
                        .angle(h_angle + heading_angle), .sin_out(sin_w),
                        .cos_out(cos_w), .done(cor_done));

  logic [24:0] sum_mag, dif_mag;
  logic [33:0] s_mag;
  logic [31:0] t_low;
  logic signed [33:0] mul_sel_s;
  logic [63:0] h_signed;
  assign sum_mag = sum_r[24] ? 25'(-sum_r) : 25'(sum_r);
  assign dif_mag = dif_r[24] ? 25'(-dif_r) : 25'(dif_r);
  assign t_low   = t_mag[31:0];
  assign mul_sel_s = (state == ST_MUL_X) ? s_lat : c_lat;
  assign s_mag   = mul_sel_s[33] ? 34'(-mul_sel_s) : 34'(mul_sel_s);
  assign h_signed = dif_r[24] ? -div_q : div_q;

  // Travel T magnitude: |dr+dl| <= 2^24, so |T| < 2^25 fits 32 bits.
  // Sign of the product T*trig is the xor of the two signs.
  logic prod_neg;
  logic signed [65:0] prod_s, upd_s;
  assign prod_neg = sum_r[24] ^ mul_sel_s[33];
  assign prod_s   = prod_neg ? -$signed({2'b00, mul_p}) : $signed({2'b00, mul_p});
  assign upd_s    = (prod_s + 66'sd536870912) >>> 30;

  // A unit is started in the first cycle of the state that uses it.
  assign enter = (state != state_prev);

  function automatic logic signed [31:0] sat(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fff_ffff;
    else if (v < -66'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      state_prev    <= ST_IDLE;
      radius        <= RADIUS_RESET;
      track_width   <= BASE_RESET;
      x_position    <= '0;
      y_position    <= '0;
      heading_angle <= '0;
      out_valid     <= 1'b0;
    end else begin
      state      <= state_next;
      state_prev <= state;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WHEEL_RADIUS: radius      <= cfg_data;
          REG_WHEEL_BASE:   track_width <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        sum_r <= 25'(in_data.right_increment) + 25'(in_data.left_increment);
        dif_r <= 25'(in_data.right_increment) - 25'(in_data.left_increment);
      end
      if (state == ST_DIV_T && div_done) t_mag <= div_q;
      if (state == ST_MUL_W && mul_done) h_mag <= mul_p;
      if (state == ST_MUL_K && mul_done) h_mag <= mul_p;
      if (state == ST_DIV_H && div_done) h_angle <= h_signed[31:0];
      if (state == ST_CORDIC && cor_done) begin
        s_lat <= sin_w;
        c_lat <= cos_w;
      end
      if (state == ST_MUL_X && mul_done) x_position <= sat(upd_s + 66'(x_position));
      if (state == ST_MUL_Y && mul_done) begin
        y_position    <= sat(upd_s + 66'(y_position));
        heading_angle <= heading_angle + {h_angle[30:0], 1'b0};
        out_valid     <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_data.pose_x  = x_position;
  assign out_data.pose_y  = y_position;
  assign out_data.heading = heading_angle;
  assign in_ready = (state == ST_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    mul_ctl = '0; div_ctl = '0; cor_ctl = '0;
    mul_a = '0; mul_b = '0; div_n = '0; div_d = 32'd1;
    unique case (state)
      ST_IDLE: if (in_valid && in_ready) state_next = ST_MUL_T;
      ST_MUL_T: begin
        mul_a = 64'(sum_mag); mul_b = 32'(radius);
        mul_ctl.start = enter;
        if (mul_done) state_next = ST_DIV_T;
      end
      ST_DIV_T: begin
        div_n = mul_p; div_d = 32'(TRAVEL_DIV);
        div_ctl.start = enter;
        if (div_done) state_next = ST_MUL_W;
      end
      ST_MUL_W: begin
        mul_a = 64'(dif_mag); mul_b = 32'(radius);
        mul_ctl.start = enter;
        if (mul_done) state_next = ST_MUL_K;
      end
      ST_MUL_K: begin
        mul_a = h_mag; mul_b = 32'(KPI);
        mul_ctl.start = enter;
        if (mul_done) state_next = ST_DIV_H;
      end
      ST_DIV_H: begin
        div_n = h_mag;
        div_d = {7'd0, (track_width == 16'd0) ? 16'd1 : track_width, 9'd0};
        div_ctl.start = enter;
        if (div_done) state_next = ST_CORDIC;
      end
      ST_CORDIC: begin
        cor_ctl.start = enter;
        if (cor_done) state_next = ST_MUL_X;
      end
      ST_MUL_X, ST_MUL_Y: begin
        mul_a = 64'(s_mag); mul_b = t_low;
        mul_ctl.start = enter;
        if (mul_done) state_next = (state == ST_MUL_X) ? ST_MUL_Y : ST_OUT;
      end
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    mul_ctl.busy = 1'b0; div_ctl.busy = 1'b0; cor_ctl.busy = 1'b0;
  end

  `DDO_ASSERT_IMP(a_top_ready_idle, clk, rst, in_ready, state == ST_IDLE,
                  "input ready outside idle")
  `DDO_ASSERT_NEXT(a_top_hold_out, clk, rst, out_valid && !out_ready, out_valid,
                   "result beat dropped before taken")
  `DDO_ASSERT_IMP(a_top_one_item, clk, rst, out_valid, !in_ready,
                  "new beat accepted while result pending")
endmodule
`default_nettype wire
